// File: sv/fsfi_pkg.sv
package fsfi_pkg;

	// Light table depth
	localparam int MAX_LIGHTS = 8;

	localparam int SLOT_W = 3;
	localparam int CFG_W  = 4;
	localparam int CNT_W  = $clog2(MAX_LIGHTS + 1);
	// Each clamped dot product stays below 2^30
	localparam int SUM_W  = 32 + $clog2(MAX_LIGHTS);
	// Width of (sum + count*2^12) >> 13
	localparam int QDIV_W = SUM_W - 12;

	localparam logic [CFG_W-1:0] LIGHT_COUNT_RST = 4'd7;
	localparam logic [15:0]      ONE_Q15         = 16'd32768;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_SHADE = 1'b1;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	typedef logic signed [15:0] q14_t;

	typedef struct packed {
		q14_t x;
		q14_t y;
		q14_t z;
	} vec_t;

	// One beat travelling down the light chain
	typedef struct packed {
		logic             valid;
		logic [CNT_W-1:0] remaining;
		vec_t             nrm;
		logic [SUM_W-1:0] sum;
	} beat_t;

	// Per-object color weights, Q1.15; unknown ids give black
	function automatic logic [15:0] color_weight(input logic [3:0] id, input logic [1:0] ch);
		logic [47:0] row;
		logic [15:0] w;
		begin
			case (id)
				4'd0: row = {16'd32768, 16'd32768, 16'd32768};
				4'd1: row = {16'd32768, 16'd16384, 16'd0};
				4'd2: row = {16'd29491, 16'd16384, 16'd13107};
				4'd3: row = {16'd16384, 16'd16384, 16'd32768};
				4'd4: row = {16'd32768, 16'd32768, 16'd32768};
				4'd5: row = {16'd32768, 16'd32768, 16'd32768};
				4'd6: row = {16'd16384, 16'd16384, 16'd32768};
				4'd7: row = {16'd16384, 16'd16384, 16'd32768};
				4'd8: row = {16'd22938, 16'd22938, 16'd32768};
				default: row = '0;
			endcase
			case (ch)
				CH_RED:   w = row[47:32];
				CH_GREEN: w = row[31:16];
				CH_BLUE:  w = row[15:0];
				default:  w = '0;
			endcase
			return w;
		end
	endfunction

endpackage

// File: sv/flat_shading_face_intensity.sv
// Flat shading with several directional lights.
// Input channel (in_valid / in_stall): one beat is either a light load
// (action = load) or a face to shade (action = shade). A load normalizes
// a_x..a_z to a Q1.14 unit vector and writes it to light_slot; it gives
// no output beat. A shade beat forms the face normal from the three
// vertices, averages the clamped dot products with the first light_count
// lights and scales the average by the object's color weights.
// Output channel (out_valid / out_stall): intensity, red, green, blue
// (Q1.15) and degenerate, one beat per shade beat.
// One item is worked at a time: the input stalls until the current
// item is through. A load runs the normalizer alone; a shade beat also
// scales the normal down, by a shift that varies with the face size, and
// a degenerate face goes straight to the output. The normalizer is a
// 32-step bit-serial square root and three 15-step divides; the light
// chain has MAX_LIGHTS cells, followed by a 23-step divide by the light count.
// Reset empties the pipeline, zeroes every light and sets light_count to 7.
// A stalled output beat holds in the output register; the block still
// takes and works the next input and waits to hand it over.
module flat_shading_face_intensity (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [fsfi_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         action,
	input  logic [fsfi_pkg::SLOT_W-1:0]  light_slot,
	input  logic [3:0]                   object_id,
	input  logic signed [31:0]           a_x,
	input  logic signed [31:0]           a_y,
	input  logic signed [31:0]           a_z,
	input  logic signed [31:0]           b_x,
	input  logic signed [31:0]           b_y,
	input  logic signed [31:0]           b_z,
	input  logic signed [31:0]           c_x,
	input  logic signed [31:0]           c_y,
	input  logic signed [31:0]           c_z,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [15:0]                  intensity,
	output logic [15:0]                  red,
	output logic [15:0]                  green,
	output logic [15:0]                  blue,
	output logic                         degenerate
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_CROSS = 9'b000000010,
		ST_ABS   = 9'b000000100,
		ST_SHIFT = 9'b000001000,
		ST_NORM  = 9'b000010000,
		ST_CHAIN = 9'b000100000,
		ST_DIV   = 9'b001000000,
		ST_COLOR = 9'b010000000,
		ST_DONE  = 9'b100000000
	} st_t;

	localparam int DCNT_W = $clog2(fsfi_pkg::QDIV_W + 1);

	// control
	st_t                               st_q;
	logic [fsfi_pkg::CFG_W-1:0]        cfg_q;
	logic                              start_q;
	logic                              tok_q;
	logic                              out_valid_q;

	// working data
	logic                              load_q;
	logic [fsfi_pkg::SLOT_W-1:0]       slot_q;
	logic [3:0]                        id_q;
	logic [fsfi_pkg::CNT_W-1:0]        count_q;
	logic signed [32:0]                e1_q [3];
	logic signed [32:0]                e2_q [3];
	logic [2:0]                        cnt_q;
	logic signed [65:0]                p_q;
	logic signed [66:0]                cr_q [3];
	logic [65:0]                       mag_q [3];
	logic [2:0]                        neg_q;
	logic [fsfi_pkg::QDIV_W-1:0]       dnum_q;
	logic [fsfi_pkg::CNT_W-1:0]        drem_q;
	logic [DCNT_W-1:0]                 dcnt_q;
	logic [15:0]                       inten_q;
	logic [15:0]                       col_q [3];
	logic                              degen_q;

	logic [15:0]                       int_o_q, red_o_q, green_o_q, blue_o_q;
	logic                              degen_o_q;

	logic                              in_acc, hand_over;
	logic [fsfi_pkg::CNT_W-1:0]        count_nx;
	logic signed [32:0]                opa, opb;
	logic signed [65:0]                prod;
	logic [2:0]                        kacc;
	logic signed [66:0]                pe;
	logic                              cr_zero, big;
	logic [31:0]                       u_mag [3];
	logic                              u_done;
	fsfi_pkg::vec_t                    u_nrm;
	logic                              wr_now;
	logic [fsfi_pkg::MAX_LIGHTS-1:0]   cell_we;
	fsfi_pkg::beat_t                   link [fsfi_pkg::MAX_LIGHTS+1];
	logic [fsfi_pkg::SUM_W:0]          nsum;
	logic [fsfi_pkg::CNT_W:0]          dtrial;
	logic                              dge;
	logic [fsfi_pkg::QDIV_W-1:0]       quot;
	logic [31:0]                       cprod, crnd;
	logic [15:0]                       wsel;

	function automatic logic [65:0] abs32(input logic signed [31:0] v);
		logic [32:0] e;
		begin
			e = v[31] ? -{v[31], v} : {v[31], v};
			return {33'd0, e};
		end
	endfunction

	assign in_stall  = (st_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign hand_over = (st_q == ST_DONE) && (!out_valid_q || !out_stall);

	// clamp the light count to 1..MAX_LIGHTS
	always_comb begin
		if (cfg_q == '0) begin
			count_nx = fsfi_pkg::CNT_W'(1);
		end else if (int'(cfg_q) > fsfi_pkg::MAX_LIGHTS) begin
			count_nx = fsfi_pkg::CNT_W'(fsfi_pkg::MAX_LIGHTS);
		end else begin
			count_nx = fsfi_pkg::CNT_W'(cfg_q);
		end
	end

	// cross product terms, one product per cycle
	always_comb begin
		case (cnt_q)
			3'd0: begin opa = e1_q[1]; opb = e2_q[2]; end
			3'd1: begin opa = e1_q[2]; opb = e2_q[1]; end
			3'd2: begin opa = e1_q[2]; opb = e2_q[0]; end
			3'd3: begin opa = e1_q[0]; opb = e2_q[2]; end
			3'd4: begin opa = e1_q[0]; opb = e2_q[1]; end
			3'd5: begin opa = e1_q[1]; opb = e2_q[0]; end
			default: begin opa = '0; opb = '0; end
		endcase
	end

	assign prod    = opa * opb;
	assign kacc    = cnt_q - 3'd1;
	assign pe      = {p_q[65], p_q};
	assign cr_zero = (cr_q[0] == '0) && (cr_q[1] == '0) && (cr_q[2] == '0);
	assign big     = |{mag_q[0][65:30], mag_q[1][65:30], mag_q[2][65:30]};

	// normalizer
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			u_mag[k] = mag_q[k][31:0];
		end
	end

	fsfi_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.mag    (u_mag),
		.neg    (neg_q),
		.done   (u_done),
		.nrm    (u_nrm)
	);

	// light chain: the normal enters at cell 0 and the running sum leaves at the end
	assign wr_now = (st_q == ST_NORM) && u_done && load_q;

	always_comb begin
		for (int g = 0; g < fsfi_pkg::MAX_LIGHTS; g++) begin
			cell_we[g] = wr_now && (int'(slot_q) == g);
		end
	end

	assign link[0].valid     = tok_q;
	assign link[0].remaining = count_q;
	assign link[0].nrm       = u_nrm;
	assign link[0].sum       = '0;

	for (genvar g = 0; g < fsfi_pkg::MAX_LIGHTS; g++) begin : g_cell
		fsfi_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.we       (cell_we[g]),
			.wr_vec   (u_nrm),
			.beat_in  (link[g]),
			.beat_out (link[g+1])
		);
	end

	// average: ((sum + count*2^12) >> 13) / count, one quotient bit a cycle
	assign nsum   = {1'b0, link[fsfi_pkg::MAX_LIGHTS].sum}
		+ (fsfi_pkg::SUM_W+1)'({count_q, 12'd0});
	assign dtrial = {drem_q, dnum_q[fsfi_pkg::QDIV_W-1]};
	assign dge    = dtrial >= {1'b0, count_q};
	assign quot   = {dnum_q[fsfi_pkg::QDIV_W-2:0], dge};

	// color scaling, rounded half up
	assign wsel  = fsfi_pkg::color_weight(id_q, cnt_q[1:0]);
	assign cprod = inten_q * wsel;
	assign crnd  = cprod + 32'd16384;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cfg_q       <= fsfi_pkg::LIGHT_COUNT_RST;
			start_q     <= 1'b0;
			tok_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// kick the normalizer for a load, or once the normal is scaled down
			start_q <= ((st_q == ST_IDLE) && in_acc && (action == fsfi_pkg::ACT_LOAD)) ||
				((st_q == ST_SHIFT) && !big);
			// launch the normal down the light chain
			tok_q   <= (st_q == ST_NORM) && u_done && !load_q;
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (hand_over) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (action == fsfi_pkg::ACT_LOAD) begin
							st_q <= ST_NORM;
						end else begin
							st_q <= ST_CROSS;
						end
					end
				end
				ST_CROSS: if (cnt_q == 3'd6) st_q <= ST_ABS;
				ST_ABS:   st_q <= cr_zero ? ST_DONE : ST_SHIFT;
				ST_SHIFT: begin
					if (!big) begin
						st_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (u_done) begin
						if (load_q) begin
							st_q <= ST_IDLE;
						end else begin
							st_q <= ST_CHAIN;
						end
					end
				end
				ST_CHAIN: if (link[fsfi_pkg::MAX_LIGHTS].valid) st_q <= ST_DIV;
				ST_DIV:   if (dcnt_q == DCNT_W'(1)) st_q <= ST_COLOR;
				ST_COLOR: if (cnt_q == 3'd2) st_q <= ST_DONE;
				ST_DONE:  if (hand_over) st_q <= ST_IDLE;
				default:  st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (in_acc) begin
					load_q  <= (action == fsfi_pkg::ACT_LOAD);
					slot_q  <= light_slot;
					id_q    <= object_id;
					count_q <= count_nx;
					cnt_q   <= '0;
					// a load normalizes the direction straight away
					mag_q[0] <= abs32(a_x);
					mag_q[1] <= abs32(a_y);
					mag_q[2] <= abs32(a_z);
					neg_q    <= {a_z[31], a_y[31], a_x[31]};
					e1_q[0]  <= {b_x[31], b_x} - {a_x[31], a_x};
					e1_q[1]  <= {b_y[31], b_y} - {a_y[31], a_y};
					e1_q[2]  <= {b_z[31], b_z} - {a_z[31], a_z};
					e2_q[0]  <= {c_x[31], c_x} - {a_x[31], a_x};
					e2_q[1]  <= {c_y[31], c_y} - {a_y[31], a_y};
					e2_q[2]  <= {c_z[31], c_z} - {a_z[31], a_z};
					for (int k = 0; k < 3; k++) begin
						cr_q[k] <= '0;
					end
				end
			end
			ST_CROSS: begin
				if (cnt_q != 3'd6) begin
					p_q <= prod;
				end
				// even terms add, odd terms subtract
				if (cnt_q != 3'd0) begin
					cr_q[kacc[2:1]] <= kacc[0] ? cr_q[kacc[2:1]] - pe : cr_q[kacc[2:1]] + pe;
				end
				cnt_q <= cnt_q + 3'd1;
			end
			ST_ABS: begin
				for (int k = 0; k < 3; k++) begin
					neg_q[k] <= cr_q[k][66];
					mag_q[k] <= cr_q[k][66] ? 66'(-cr_q[k]) : cr_q[k][65:0];
				end
				degen_q <= cr_zero;
				if (cr_zero) begin
					inten_q <= '0;
					for (int k = 0; k < 3; k++) begin
						col_q[k] <= '0;
					end
				end
			end
			ST_SHIFT: begin
				// common truncating scale until every magnitude is below 2^30
				if (big) begin
					for (int k = 0; k < 3; k++) begin
						mag_q[k] <= mag_q[k] >> 1;
					end
				end
			end
			ST_CHAIN: begin
				if (link[fsfi_pkg::MAX_LIGHTS].valid) begin
					dnum_q <= nsum[fsfi_pkg::SUM_W:13];
					drem_q <= '0;
					dcnt_q <= DCNT_W'(fsfi_pkg::QDIV_W);
				end
			end
			ST_DIV: begin
				drem_q <= dge ? fsfi_pkg::CNT_W'(dtrial - {1'b0, count_q}) :
					dtrial[fsfi_pkg::CNT_W-1:0];
				dnum_q <= quot;
				dcnt_q <= dcnt_q - DCNT_W'(1);
				if (dcnt_q == DCNT_W'(1)) begin
					inten_q <= (quot > fsfi_pkg::QDIV_W'(fsfi_pkg::ONE_Q15)) ?
						fsfi_pkg::ONE_Q15 : quot[15:0];
					cnt_q   <= '0;
				end
			end
			ST_COLOR: begin
				col_q[cnt_q[1:0]] <= crnd[30:15];
				cnt_q             <= cnt_q + 3'd1;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (hand_over) begin
			int_o_q   <= inten_q;
			red_o_q   <= col_q[fsfi_pkg::CH_RED];
			green_o_q <= col_q[fsfi_pkg::CH_GREEN];
			blue_o_q  <= col_q[fsfi_pkg::CH_BLUE];
			degen_o_q <= degen_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign intensity  = int_o_q;
	assign red        = red_o_q;
	assign green      = green_o_q;
	assign blue       = blue_o_q;
	assign degenerate = degen_o_q;

endmodule

// File: sv/fsfi_cell.sv
// One light table entry; adds its clamped dot product to the passing beat.
module fsfi_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            we,
	input  fsfi_pkg::vec_t  wr_vec,
	input  fsfi_pkg::beat_t beat_in,
	output fsfi_pkg::beat_t beat_out
);

	fsfi_pkg::vec_t                   light_q;
	logic                             valid_q;
	logic [fsfi_pkg::CNT_W-1:0]       rem_q;
	fsfi_pkg::vec_t                   nrm_q;
	logic [fsfi_pkg::SUM_W-1:0]       sum_q;

	logic signed [31:0]               px, py, pz, dot;
	logic [fsfi_pkg::SUM_W-1:0]       add;

	assign px  = beat_in.nrm.x * light_q.x;
	assign py  = beat_in.nrm.y * light_q.y;
	assign pz  = beat_in.nrm.z * light_q.z;
	assign dot = px + py + pz;

	// drop negative terms and lights past the active count
	assign add = (beat_in.remaining != '0 && dot > 0) ?
		fsfi_pkg::SUM_W'(dot[30:0]) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (we) begin
				light_q <= wr_vec;
			end
			valid_q <= beat_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_q <= (beat_in.remaining != '0) ?
			beat_in.remaining - fsfi_pkg::CNT_W'(1) : '0;
		nrm_q <= beat_in.nrm;
		sum_q <= beat_in.sum + add;
	end

	assign beat_out.valid     = valid_q;
	assign beat_out.remaining = rem_q;
	assign beat_out.nrm       = nrm_q;
	assign beat_out.sum       = sum_q;

endmodule

// File: sv/fsfi_unit.sv
// Unit vector in Q1.14: sum of squares, bit-serial square root, then
// three restoring divides of 15 steps.
module fsfi_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [31:0]    mag [3],
	input  logic [2:0]     neg,
	output logic           done,
	output fsfi_pkg::vec_t nrm
);

	typedef enum logic [4:0] {
		U_IDLE = 5'b00001,
		U_SQ   = 5'b00010,
		U_ROOT = 5'b00100,
		U_PREP = 5'b01000,
		U_DIV  = 5'b10000
	} ust_t;

	ust_t                 st_q;
	logic                 done_q;
	logic [31:0]          mag_q [3];
	logic [2:0]           neg_q;
	logic [1:0]           k_q;
	logic [63:0]          acc_q, v_q, r_q, bit_q;
	logic [31:0]          len_q;
	logic [46:0]          rem_q, dsh_q;
	logic [3:0]           step_q;
	logic [14:0]          q_q;
	fsfi_pkg::q14_t       comp_q [3];

	logic [63:0]          sq, trial, r_nx;
	logic                 ge, take;
	logic [14:0]          q_nx;
	logic signed [15:0]   qmag, val;

	assign sq    = mag_q[k_q] * mag_q[k_q];
	assign trial = r_q + bit_q;
	assign ge    = v_q >= trial;
	assign r_nx  = ge ? (r_q >> 1) + bit_q : (r_q >> 1);
	assign take  = rem_q >= dsh_q;
	assign q_nx  = {q_q[13:0], take};
	assign qmag  = {1'b0, q_nx};
	assign val   = (len_q == '0) ? '0 : (neg_q[k_q] ? -qmag : qmag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= U_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= (st_q == U_DIV) && (step_q == '0) && (k_q == 2'd2);
			case (st_q)
				U_IDLE: if (start) st_q <= U_SQ;
				U_SQ:   if (k_q == 2'd2) st_q <= U_ROOT;
				U_ROOT: if (bit_q[0]) st_q <= U_PREP;
				U_PREP: st_q <= U_DIV;
				U_DIV: begin
					if (step_q == '0) begin
						if (k_q == 2'd2) begin
							st_q <= U_IDLE;
						end else begin
							st_q <= U_PREP;
						end
					end
				end
				default: st_q <= U_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			U_IDLE: begin
				if (start) begin
					mag_q <= mag;
					neg_q <= neg;
					k_q   <= '0;
					acc_q <= '0;
				end
			end
			U_SQ: begin
				acc_q <= acc_q + sq;
				k_q   <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				if (k_q == 2'd2) begin
					v_q   <= acc_q + sq;
					r_q   <= '0;
					bit_q <= 64'd1 << 62;
				end
			end
			U_ROOT: begin
				if (ge) begin
					v_q <= v_q - trial;
				end
				r_q   <= r_nx;
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					len_q <= r_nx[31:0];
				end
			end
			U_PREP: begin
				// rounding half up: add len/2 before the divide
				rem_q  <= 47'({mag_q[k_q], 14'd0}) + 47'(len_q[31:1]);
				dsh_q  <= 47'({len_q, 14'd0});
				step_q <= 4'd14;
				q_q    <= '0;
			end
			U_DIV: begin
				if (take) begin
					rem_q <= rem_q - dsh_q;
				end
				dsh_q  <= dsh_q >> 1;
				q_q    <= q_nx;
				step_q <= step_q - 4'd1;
				if (step_q == '0) begin
					comp_q[k_q] <= val;
					k_q         <= k_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

	assign done  = done_q;
	assign nrm.x = comp_q[0];
	assign nrm.y = comp_q[1];
	assign nrm.z = comp_q[2];

endmodule

// File: sv/fsfi_checker.sv
module fsfi_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [15:0]                  intensity,
	input logic [15:0]                  red,
	input logic [15:0]                  green,
	input logic [15:0]                  blue,
	input logic                         degenerate
);

	logic in_acc;

	assign in_acc = in_valid && !in_stall;

	// a held beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	// the block is busy right after it takes a beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("input taken while still working");

	// no result appears in the cycle after a beat is taken
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !$rose(out_valid))
		else $error("result appeared too early");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> intensity == 16'd0 && red == 16'd0 &&
			green == 16'd0 && blue == 16'd0)
		else $error("degenerate face with nonzero color");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> intensity <= fsfi_pkg::ONE_Q15 && red <= intensity &&
			green <= intensity && blue <= intensity)
		else $error("output out of range");

endmodule

bind flat_shading_face_intensity fsfi_checker u_fsfi_checker (.*);

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	// One input beat: a light load or a face to shade. Index 0 is x, 2 is z.
	typedef struct packed {
		logic             act;
		logic [2:0]       slot;
		logic [3:0]       obj;
		logic [2:0][31:0] a;
		logic [2:0][31:0] b;
		logic [2:0][31:0] c;
	} face_item_t;

	typedef struct packed {
		logic [15:0] inten;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic        degen;
	} shade_result_t;

	// Drain margin after the last expected beat: a load gives no beat but
	// still occupies the block.
	localparam int DRAIN_CYCLES = 300;
	localparam int HOLD_CYCLES  = 1500;
	localparam logic [31:0] I32_MIN = 32'h8000_0000;
	localparam logic [31:0] I32_MAX = 32'h7fff_ffff;
	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [fsfi_pkg::CFG_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_stall;
	logic action;
	logic [fsfi_pkg::SLOT_W-1:0] light_slot;
	logic [3:0] object_id;
	logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
	logic out_valid;
	logic out_stall;
	logic [15:0] intensity, red, green, blue;
	logic degenerate;

	// Shadow state of the block
	fsfi_pkg::vec_t             light_shadow [fsfi_pkg::MAX_LIGHTS];
	logic [fsfi_pkg::CFG_W-1:0] count_shadow;
	shade_result_t              shade_expected [$];

	int  error_count;
	bit  quiet;      // no idling on either side while set
	bit  hold_req;   // ask the receiver for one long hold-off

	flat_shading_face_intensity u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.light_slot (light_slot),
		.object_id  (object_id),
		.a_x        (a_x),
		.a_y        (a_y),
		.a_z        (a_z),
		.b_x        (b_x),
		.b_y        (b_y),
		.b_z        (b_z),
		.c_x        (c_x),
		.c_y        (c_y),
		.c_z        (c_z),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.intensity  (intensity),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.degenerate (degenerate)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard limit, far beyond the slowest legal run
	initial begin
		#4_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] bitpos;
		root   = '0;
		bitpos = 64'h4000_0000_0000_0000;
		while (bitpos > v) bitpos = bitpos >> 2;
		while (bitpos != 0) begin
			if (v >= root + bitpos) begin
				v    = v - (root + bitpos);
				root = (root >> 1) + bitpos;
			end else begin
				root = root >> 1;
			end
			bitpos = bitpos >> 2;
		end
		return root;
	endfunction

	// Scale magnitudes (each below 2^32) to a Q1.14 unit vector, round half up
	function automatic fsfi_pkg::vec_t to_unit(input logic [2:0][63:0] mag,
	                                           input logic [2:0] neg);
		logic [63:0] len;
		logic [63:0] q;
		logic [2:0][15:0] comp;
		len = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
		for (int k = 0; k < 3; k++) begin
			q = (len == 0) ? 64'd0 : (mag[k] * 64'd16384 + len / 2) / len;
			comp[k] = neg[k] ? -q[15:0] : q[15:0];
		end
		return '{x: comp[0], y: comp[1], z: comp[2]};
	endfunction

	function automatic logic [15:0] object_weight(input logic [3:0] id, input int ch);
		logic [15:0] rom [9][3];
		rom = '{'{16'd32768, 16'd32768, 16'd32768}, '{16'd32768, 16'd16384, 16'd0},
		        '{16'd29491, 16'd16384, 16'd13107}, '{16'd16384, 16'd16384, 16'd32768},
		        '{16'd32768, 16'd32768, 16'd32768}, '{16'd32768, 16'd32768, 16'd32768},
		        '{16'd16384, 16'd16384, 16'd32768}, '{16'd16384, 16'd16384, 16'd32768},
		        '{16'd22938, 16'd22938, 16'd32768}};
		return (id <= 4'd8) ? rom[id][ch] : 16'd0;
	endfunction

	// Apply one accepted beat to the shadow state; queue the shade result
	function automatic void predict_beat(input face_item_t it);
		logic [2:0][63:0]  mag;
		logic [2:0]        neg;
		logic signed [71:0] e1 [3];
		logic signed [71:0] e2 [3];
		logic signed [71:0] cr [3];
		logic [71:0]       cm [3];
		fsfi_pkg::vec_t    nrm;
		logic [63:0]       sum;
		logic [63:0]       cnt;
		logic [63:0]       inten;
		longint            d;
		shade_result_t     res;
		logic signed [31:0] sa, sb, sc;

		if (it.act == fsfi_pkg::ACT_LOAD) begin
			for (int k = 0; k < 3; k++) begin
				sa = it.a[k];
				neg[k] = sa[31];
				mag[k] = sa[31] ? 64'(-longint'(sa)) : 64'(sa);
			end
			light_shadow[it.slot] = to_unit(mag, neg);
			return;
		end

		for (int k = 0; k < 3; k++) begin
			sa = it.a[k];
			sb = it.b[k];
			sc = it.c[k];
			e1[k] = 72'(sb) - 72'(sa);
			e2[k] = 72'(sc) - 72'(sa);
		end
		cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
		cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
		cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
		for (int k = 0; k < 3; k++) begin
			neg[k] = cr[k] < 0;
			cm[k]  = neg[k] ? -cr[k] : cr[k];
		end

		res = '0;
		if (cm[0] == 0 && cm[1] == 0 && cm[2] == 0) begin
			res.degen = 1'b1;
			shade_expected = {shade_expected, res};
			return;
		end
		// Common truncating shift until every component is below 2^30
		while (cm[0] >= 72'h4000_0000 || cm[1] >= 72'h4000_0000 || cm[2] >= 72'h4000_0000)
			for (int k = 0; k < 3; k++) cm[k] = cm[k] >> 1;
		for (int k = 0; k < 3; k++) mag[k] = cm[k][63:0];
		nrm = to_unit(mag, neg);

		cnt = 64'(count_shadow);
		if (cnt < 1) cnt = 1;
		if (cnt > fsfi_pkg::MAX_LIGHTS) cnt = fsfi_pkg::MAX_LIGHTS;
		sum = '0;
		for (int k = 0; k < cnt; k++) begin
			d = longint'(nrm.x) * longint'(light_shadow[k].x)
			  + longint'(nrm.y) * longint'(light_shadow[k].y)
			  + longint'(nrm.z) * longint'(light_shadow[k].z);
			if (d > 0) sum = sum + 64'(d);
		end
		inten = (sum + cnt * 4096) / (cnt * 8192);
		if (inten > 32768) inten = 32768;
		res.inten = inten[15:0];
		res.red   = 16'((inten * object_weight(it.obj, 0) + 16384) >> 15);
		res.green = 16'((inten * object_weight(it.obj, 1) + 16384) >> 15);
		res.blue  = 16'((inten * object_weight(it.obj, 2) + 16384) >> 15);
		shade_expected = {shade_expected, res};
	endfunction

	// ---------------------------------------------------------------
	// Result checker: compare every handed-over beat with the oldest
	// expectation. Sample at the falling edge, where stall and valid are
	// settled, so the beat moves at the next rising edge.
	// ---------------------------------------------------------------

	task automatic check_field(input string name, input logic [15:0] exp_v,
	                           input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			error_count++;
		end
	endtask

	initial begin
		shade_result_t want;
		forever begin
			@(negedge clk);
			if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
				if (shade_expected.size() == 0) begin
					$error("unexpected output beat: intensity %0d", intensity);
					error_count++;
				end else begin
					want = shade_expected.pop_front();
					check_field("intensity", want.inten, intensity);
					check_field("red", want.red, red);
					check_field("green", want.green, green);
					check_field("blue", want.blue, blue);
					check_field("degenerate", 16'(want.degen), 16'(degenerate));
				end
			end
		end
	end

	// Receiver: random stall, or one long counted hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
			end
			out_stall <= !quiet && ($urandom_range(0, 99) < 34);
		end
	end

	// ---------------------------------------------------------------
	// Sender helpers
	// ---------------------------------------------------------------

	// Offer one beat, hold it until taken, then update the shadow state
	task automatic send_beat(input face_item_t it);
		if (!quiet && $urandom_range(0, 99) < 34) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= it.act;
		light_slot <= it.slot;
		object_id  <= it.obj;
		{a_z, a_y, a_x} <= it.a;
		{b_z, b_y, b_x} <= it.b;
		{c_z, c_y, c_x} <= it.c;
		forever begin
			@(negedge clk);
			if (!in_stall) break;
		end
		@(posedge clk);
		predict_beat(it);
	endtask

	// Drop valid, drain every expected beat, then cover in-flight loads
	task automatic drain_block();
		in_valid <= 1'b0;
		while (shade_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_light_count(input logic [fsfi_pkg::CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		count_shadow = value;
	endtask

	function automatic face_item_t make_load(input logic [2:0] slot, input logic [31:0] x,
	                                         input logic [31:0] y, input logic [31:0] z);
		face_item_t it;
		it      = '0;
		it.act  = fsfi_pkg::ACT_LOAD;
		it.slot = slot;
		it.obj  = 4'($urandom);
		it.a    = {z, y, x};
		it.b    = {$urandom, $urandom, $urandom};
		it.c    = {$urandom, $urandom, $urandom};
		return it;
	endfunction

	function automatic face_item_t make_face(input logic [3:0] obj,
	                                         input logic [2:0][31:0] a,
	                                         input logic [2:0][31:0] b,
	                                         input logic [2:0][31:0] c);
		face_item_t it;
		it      = '0;
		it.act  = fsfi_pkg::ACT_SHADE;
		it.slot = 3'($urandom);
		it.obj  = obj;
		it.a    = a;
		it.b    = b;
		it.c    = c;
		return it;
	endfunction

	// Right-triangle face with unit legs in the xy plane, normal along +z
	function automatic face_item_t flat_face(input logic [3:0] obj);
		return make_face(obj, '0, {32'd0, 32'd0, ONE_Q16}, {32'd0, ONE_Q16, 32'd0});
	endfunction

	// Coordinate spread: full range, small and medium spans, and edge values
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0, 1: return $urandom;
			2:    return 32'($signed($urandom_range(0, 2 * 65536)) - 65536);
			3:    return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
			4:    return 32'($signed($urandom_range(0, 2000)) - 1000);
			default: begin
				case ($urandom_range(0, 3))
					0: return I32_MIN;
					1: return I32_MAX;
					2: return 32'hffff_ffff;
					default: return 32'd0;
				endcase
			end
		endcase
	endfunction

	function automatic logic [2:0][31:0] rand_point();
		return {rand_coord(), rand_coord(), rand_coord()};
	endfunction

	function automatic face_item_t rand_item();
		logic [2:0][31:0] pa, pb, pc;
		if ($urandom_range(0, 99) < 15) begin
			if ($urandom_range(0, 9) == 0)
				return make_load(3'($urandom), 32'd0, 32'd0, 32'd0);
			return make_load(3'($urandom), rand_coord(), rand_coord(), rand_coord());
		end
		pa = rand_point();
		pb = rand_point();
		pc = rand_point();
		// Some collinear or coincident vertices give degenerate faces
		case ($urandom_range(0, 19))
			0: pc = pa;
			1: pc = pb;
			2: begin
				pb = pa;
				pc = pa;
			end
			default: ;
		endcase
		return make_face(4'($urandom), pa, pb, pc);
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Lights are zero after reset: shading gives zero intensity
	task automatic test_reset_state();
		send_beat(flat_face(4'd0));
		drain_block();
	endtask

	// Fill every slot, with zero, extreme and tiny directions
	task automatic test_light_loads();
		send_beat(make_load(3'd0, 32'd0, 32'd0, ONE_Q16));
		send_beat(make_load(3'd1, I32_MAX, I32_MAX, I32_MAX));
		send_beat(make_load(3'd2, I32_MIN, I32_MIN, I32_MIN));
		send_beat(make_load(3'd3, 32'd0, 32'd0, 32'd0));
		send_beat(make_load(3'd4, 32'hffff_ffff, 32'd0, 32'd0));
		send_beat(make_load(3'd5, 32'd0, I32_MIN, 32'd1));
		send_beat(make_load(3'd6, 32'd1, 32'd1, 32'd1));
		send_beat(make_load(3'd7, 32'd0, 32'd0, 32'hffff_fffb));
		send_beat(flat_face(4'd0));
		drain_block();
	endtask

	// Count zero, one, the table size and beyond it
	task automatic test_light_counts();
		logic [fsfi_pkg::CFG_W-1:0] counts [4];
		counts = '{4'd0, 4'd1, 4'd8, 4'd15};
		foreach (counts[i]) begin
			write_light_count(counts[i]);
			send_beat(flat_face(4'd2));
			drain_block();
		end
	endtask

	// Known colors and ids past the table
	task automatic test_objects();
		logic [3:0] ids [6];
		ids = '{4'd0, 4'd1, 4'd2, 4'd8, 4'd9, 4'd15};
		foreach (ids[i]) send_beat(flat_face(ids[i]));
		drain_block();
	endtask

	// Coincident and collinear vertices, then two faces spanning the full coordinate range
	task automatic test_degenerate_and_extremes();
		send_beat(make_face(4'd3, {3{I32_MAX}}, {3{I32_MAX}}, {3{I32_MAX}}));
		send_beat(make_face(4'd4, '0, {3{ONE_Q16}}, {3{32'h0002_0000}}));
		send_beat(make_face(4'd5, {3{I32_MIN}}, {I32_MIN, I32_MIN, I32_MAX},
		                    {I32_MIN, I32_MAX, I32_MIN}));
		send_beat(make_face(4'd6, {3{I32_MAX}}, {I32_MAX, I32_MAX, I32_MIN},
		                    {I32_MAX, I32_MIN, I32_MAX}));
		drain_block();
	endtask

	// Hold the output long enough that the block fills and stalls its input
	task automatic test_output_backpressure();
		hold_req = 1'b1;
		repeat (8) send_beat(rand_item());
		drain_block();
	endtask

	// Random phases, each under a fresh light count; one phase runs without idling
	task automatic test_random_traffic();
		for (int phase = 0; phase < 6; phase++) begin
			write_light_count((phase == 0) ? 4'd8 : 4'($urandom));
			quiet = (phase == 3);
			repeat (270) send_beat(rand_item());
			drain_block();
		end
		quiet = 1'b0;
	endtask

	initial begin
		error_count  = 0;
		quiet        = 1'b0;
		hold_req     = 1'b0;
		count_shadow = fsfi_pkg::LIGHT_COUNT_RST;
		foreach (light_shadow[i]) light_shadow[i] = '0;

		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_wdata  <= '0;
		in_valid   <= 1'b0;
		out_stall  <= 1'b0;
		action     <= fsfi_pkg::ACT_LOAD;
		light_slot <= '0;
		object_id  <= '0;
		{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_light_loads();
		test_light_counts();
		test_objects();
		test_degenerate_and_extremes();
		test_output_backpressure();
		test_random_traffic();

		if (error_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
